// ----- design/knn_pkg.sv -----
// Package for the k-nearest-neighbor classifier.
// Holds default sizes and the fixed widths of the stream fields.
// Used by knn_classifier_unit, knn_checker and tb_knn_classifier_unit.
`default_nettype none

package knn_pkg;

    // default sizes of the stores
    localparam int MaxSamplesDef = 256;
    localparam int MaxDimsDef    = 16;
    localparam int MaxClassesDef = 8;
    localparam int CoordWidthDef = 16;

    // fixed field widths
    localparam int SiW    = 8;   // sample_index
    localparam int DiW    = 4;   // dim_index
    localparam int LabW   = 4;   // label, class_label, decided_class
    localparam int VoteW  = 9;   // vote_count and neighbour_count
    localparam int RadW   = 19;  // radius
    localparam int FuncW  = 2;
    localparam int CfgIdxW = 2;
    localparam int CfgW   = 9;
    localparam int InDataW  = 32;
    localparam int OutDataW = 40;

    // input kinds
    localparam logic [FuncW-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FuncW-1:0] FUNC_LABEL  = 2'd1;
    localparam logic [FuncW-1:0] FUNC_QUERY  = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_NEIGHBOURS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SAMPLES    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DIMS       = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_CLASSES    = 2'd3;

endpackage

`default_nettype wire

// ----- design/knn_classifier_unit.sv -----
// k-nearest-neighbor classifier, top level.
// Depends on knn_pkg and knn_ram.
//
// Words with tuser FUNC_SAMPLE or FUNC_LABEL store training data. A FUNC_QUERY
// word stores one query coordinate; with tlast it starts a classification, during
// which s_axis_tready stays low. A classification computes the distances (one
// squared difference per cycle through a single multiplier), then runs one round
// per chosen neighbor, each round one pass of the distance memory's read port,
// then the vote decision over the nc classes, the bit-serial square root, and nc
// result words (ns, nd, nc as configured, saturated at the store sizes). No
// clearing pass is needed after reset.
`default_nettype none

module knn_classifier_unit
    import knn_pkg::*;
#(
    parameter int MAX_SAMPLES = MaxSamplesDef,
    parameter int MAX_DIMS    = MaxDimsDef,
    parameter int MAX_CLASSES = MaxClassesDef,
    parameter int COORD_WIDTH = CoordWidthDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration write port
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgW-1:0]     i_cfg_data,
    // input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // sample_index[7:0], dim_index[11:8], coord_value[27:12], label[31:28]
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    // func[1:0]
    input  wire logic [FuncW-1:0]    s_axis_tuser,
    // last_coordinate
    input  wire logic                s_axis_tlast,
    // result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // class_label[3:0], vote_count[12:4], decided_class[16:13], radius[35:17],
    // short_of_neighbours[36], zeros[39:37]
    output logic [OutDataW-1:0]      m_axis_tdata,
    // last_class
    output logic                     m_axis_tlast
);

    localparam int SIW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int DIW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CIW  = $clog2(MAX_CLASSES);
    localparam int SAW  = (MAX_SAMPLES * MAX_DIMS > 1) ? $clog2(MAX_SAMPLES * MAX_DIMS) : 1;
    localparam int BAW  = $clog2(MAX_SAMPLES * MAX_DIMS + 1);
    localparam int NSW  = $clog2(MAX_SAMPLES + 1);
    localparam int NDW  = $clog2(MAX_DIMS + 1);
    localparam int NCW  = $clog2(MAX_CLASSES + 1);
    localparam int PW   = 2 * COORD_WIDTH + 2;
    localparam int DW   = PW + $clog2(MAX_DIMS);
    localparam int SQW  = DW + (DW % 2);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIST = 8'b0000_0010,
        S_SEL  = 8'b0000_0100,
        S_LBL  = 8'b0000_1000,
        S_VOTE = 8'b0001_0000,
        S_DEC  = 8'b0010_0000,
        S_SQRT = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [VoteW-1:0] r_cfg_k;
    logic [CfgW-1:0]  r_cfg_ns;
    logic [4:0]       r_cfg_nd;
    logic [3:0]       r_cfg_nc;

    // per-query settings
    logic [VoteW-1:0] r_k;
    logic [NSW-1:0]   r_ns;
    logic [NDW-1:0]   r_nd;
    logic [NCW-1:0]   r_nc;

    // input fields
    logic [SiW-1:0]         in_si;
    logic [DiW-1:0]         in_di;
    logic [COORD_WIDTH-1:0] in_val;
    logic [LabW-1:0]        in_lab;
    logic                   in_acc;
    logic                   si_ok, di_ok;

    assign in_si  = s_axis_tdata[7:0];
    assign in_di  = s_axis_tdata[11:8];
    assign in_val = COORD_WIDTH'(s_axis_tdata[27:12]);
    assign in_lab = s_axis_tdata[31:28];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign si_ok  = 32'(in_si) < MAX_SAMPLES;
    assign di_ok  = 32'(in_di) < MAX_DIMS;
    assign s_axis_tready = (r_state == S_IDLE);

    // saturated counts from the registers
    logic [NSW-1:0] n_ns;
    logic [NDW-1:0] n_nd;
    logic [NCW-1:0] n_nc;

    always_comb begin
        n_nd = (32'(r_cfg_nd) > MAX_DIMS) ? NDW'(MAX_DIMS) : NDW'(r_cfg_nd);
        if (n_nd == '0) begin
            n_ns = '0;
        end else begin
            n_ns = (32'(r_cfg_ns) > MAX_SAMPLES) ? NSW'(MAX_SAMPLES) : NSW'(r_cfg_ns);
        end
        if (r_cfg_nc == '0) begin
            n_nc = NCW'(1);
        end else begin
            n_nc = (32'(r_cfg_nc) > MAX_CLASSES) ? NCW'(MAX_CLASSES) : NCW'(r_cfg_nc);
        end
    end

    // loop counters
    logic [NSW-1:0] r_si;
    logic [NDW-1:0] r_d;
    logic [BAW-1:0] r_base;
    logic           r_issue;

    // distance pipeline
    logic            r_p1_v, r_p1_first, r_p1_last;
    logic [SIW-1:0]  r_p1_s;
    logic            r_p2_v, r_p2_first, r_p2_last;
    logic [SIW-1:0]  r_p2_s;
    logic [PW-1:0]   r_prod;
    logic [DW-1:0]   r_acc;
    logic [DW-1:0]   n_sum;

    // selection
    logic            r_scan, r_q1_v, r_found, r_first_round;
    logic [SIW-1:0]  r_q1_s, r_pick, r_prev_i;
    logic [DW-1:0]   r_best, r_prev_d, r_kth;
    logic [VoteW-1:0] r_round;
    logic            r_short;

    // votes and decision
    logic [VoteW-1:0] r_votes [MAX_CLASSES];
    logic [CIW-1:0]   r_cls, r_best_cls;
    logic [VoteW-1:0] r_best_votes;

    // square root
    logic [SQW-1:0] r_rem, r_root, r_bit;
    logic [SQW-1:0] n_try;

    // memory ports
    logic [COORD_WIDTH-1:0] sample_q, query_q;
    logic [DW-1:0]          dist_q;
    logic [LabW-1:0]        label_q;

    knn_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_SAMPLES * MAX_DIMS)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && s_axis_tuser == FUNC_SAMPLE && si_ok && di_ok),
        .i_waddr (SAW'(32'(in_si) * MAX_DIMS + 32'(in_di))),
        .i_wdata (in_val),
        .i_raddr (SAW'(32'(r_base) + 32'(r_d))),
        .o_rdata (sample_q)
    );

    knn_ram #(.WIDTH(LabW), .DEPTH(MAX_SAMPLES)) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && s_axis_tuser == FUNC_LABEL && si_ok),
        .i_waddr (SIW'(in_si)),
        .i_wdata (in_lab),
        .i_raddr (r_pick),
        .o_rdata (label_q)
    );

    knn_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_DIMS)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && s_axis_tuser == FUNC_QUERY && di_ok),
        .i_waddr (DIW'(in_di)),
        .i_wdata (in_val),
        .i_raddr (DIW'(r_d)),
        .o_rdata (query_q)
    );

    knn_ram #(.WIDTH(DW), .DEPTH(MAX_SAMPLES)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (r_p2_v && r_p2_last),
        .i_waddr (r_p2_s),
        .i_wdata (n_sum),
        .i_raddr (SIW'(r_si)),
        .o_rdata (dist_q)
    );

    // squared difference of one coordinate pair
    logic signed [COORD_WIDTH:0] diff;
    logic signed [PW-1:0]        sq;

    assign diff  = $signed({sample_q[COORD_WIDTH-1], sample_q})
                 - $signed({query_q[COORD_WIDTH-1], query_q});
    assign sq    = diff * diff;
    assign n_sum = (r_p2_first ? '0 : r_acc) + DW'(r_prod);

    // candidate test for the current selection round
    logic cand;

    assign cand = (dist_q != '0) && (r_first_round || dist_q > r_prev_d
                  || (dist_q == r_prev_d && r_q1_s > r_prev_i));

    // vote of the chosen label
    logic lab_ok;

    assign lab_ok = (label_q != '0) && (32'(label_q) <= 32'(r_nc));
    assign n_try  = r_root + r_bit;

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg_k  <= VoteW'(1);
            r_cfg_ns <= CfgW'(256);
            r_cfg_nd <= 5'd16;
            r_cfg_nc <= 4'd8;
            r_issue  <= 1'b0;
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_scan   <= 1'b0;
            r_q1_v   <= 1'b0;
            r_short  <= 1'b0;
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_votes[i] <= '0;
            end
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NEIGHBOURS: r_cfg_k  <= i_cfg_data;
                    CFG_SAMPLES:    r_cfg_ns <= i_cfg_data;
                    CFG_DIMS:       r_cfg_nd <= i_cfg_data[4:0];
                    CFG_CLASSES:    r_cfg_nc <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            // distance pipeline stages
            r_p1_v     <= r_issue;
            r_p1_first <= (r_d == '0);
            r_p1_last  <= (32'(r_d) == 32'(r_nd) - 1);
            r_p1_s     <= SIW'(r_si);
            r_p2_v     <= r_p1_v;
            r_p2_first <= r_p1_first;
            r_p2_last  <= r_p1_last;
            r_p2_s     <= r_p1_s;
            r_prod     <= PW'(unsigned'(sq));
            if (r_p2_v) begin
                r_acc <= n_sum;
            end

            // selection read pipeline
            r_q1_v <= r_scan;
            r_q1_s <= SIW'(r_si);

            case (r_state)
                S_IDLE: begin
                    if (in_acc && s_axis_tuser == FUNC_QUERY && s_axis_tlast) begin
                        r_k           <= r_cfg_k;
                        r_ns          <= n_ns;
                        r_nd          <= n_nd;
                        r_nc          <= n_nc;
                        r_short       <= 1'b0;
                        r_kth         <= '0;
                        r_round       <= '0;
                        r_first_round <= 1'b1;
                        r_found       <= 1'b0;
                        r_si          <= '0;
                        r_d           <= '0;
                        r_base        <= '0;
                        for (int i = 0; i < MAX_CLASSES; i++) begin
                            r_votes[i] <= '0;
                        end
                        if (n_ns == '0) begin
                            r_scan  <= 1'b0;
                            r_state <= S_SEL;
                        end else begin
                            r_issue <= 1'b1;
                            r_state <= S_DIST;
                        end
                    end
                end

                S_DIST: begin
                    // advance over coordinates, then samples
                    if (r_issue) begin
                        if (32'(r_d) == 32'(r_nd) - 1) begin
                            r_d    <= '0;
                            r_base <= BAW'(32'(r_base) + MAX_DIMS);
                            if (32'(r_si) == 32'(r_ns) - 1) begin
                                r_issue <= 1'b0;
                                r_si    <= '0;
                            end else begin
                                r_si <= r_si + 1'b1;
                            end
                        end else begin
                            r_d <= r_d + 1'b1;
                        end
                    end else if (!r_p1_v && !r_p2_v) begin
                        r_si    <= '0;
                        r_scan  <= 1'b1;
                        r_found <= 1'b0;
                        r_state <= S_SEL;
                    end
                end

                S_SEL: begin
                    // walk the distance memory once
                    if (r_scan) begin
                        if (32'(r_si) == 32'(r_ns) - 1) begin
                            r_scan <= 1'b0;
                        end
                        r_si <= r_si + 1'b1;
                    end
                    if (r_q1_v && cand && (!r_found || dist_q < r_best)) begin
                        r_found <= 1'b1;
                        r_best  <= dist_q;
                        r_pick  <= r_q1_s;
                    end
                    if (!r_scan && !r_q1_v) begin
                        r_cls        <= '0;
                        r_best_cls   <= '0;
                        r_best_votes <= '0;
                        if (r_k == '0) begin
                            r_state <= S_DEC;
                        end else if (!r_found) begin
                            r_short <= 1'b1;
                            r_state <= S_DEC;
                        end else begin
                            r_prev_d      <= r_best;
                            r_prev_i      <= r_pick;
                            r_kth         <= r_best;
                            r_first_round <= 1'b0;
                            r_state       <= S_LBL;
                        end
                    end
                end

                S_LBL: begin
                    // label read in flight
                    r_state <= S_VOTE;
                end

                S_VOTE: begin
                    if (lab_ok) begin
                        r_votes[CIW'(label_q - 1'b1)] <= r_votes[CIW'(label_q - 1'b1)] + 1'b1;
                    end
                    r_round <= r_round + 1'b1;
                    if (r_round + 1'b1 == r_k) begin
                        r_state <= S_DEC;
                    end else begin
                        r_si    <= '0;
                        r_scan  <= (r_ns != '0);
                        r_found <= 1'b0;
                        r_state <= S_SEL;
                    end
                end

                S_DEC: begin
                    // keep the first class with the most votes
                    if (r_votes[r_cls] > r_best_votes) begin
                        r_best_votes <= r_votes[r_cls];
                        r_best_cls   <= r_cls;
                    end
                    if (32'(r_cls) == 32'(r_nc) - 1) begin
                        r_rem   <= SQW'(r_kth);
                        r_root  <= '0;
                        r_bit   <= SQW'(1) << (SQW - 2);
                        r_state <= S_SQRT;
                    end else begin
                        r_cls <= r_cls + 1'b1;
                    end
                end

                S_SQRT: begin
                    // one root bit per cycle
                    if (r_rem >= n_try) begin
                        r_rem  <= r_rem - n_try;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_cls   <= '0;
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (m_axis_tready) begin
                        if (32'(r_cls) == 32'(r_nc) - 1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cls <= r_cls + 1'b1;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result word
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tlast  = (32'(r_cls) == 32'(r_nc) - 1);
    assign m_axis_tdata  = {3'b000, r_short, RadW'(r_root),
                            LabW'(32'(r_best_cls) + 1), r_votes[r_cls],
                            LabW'(32'(r_cls) + 1)};

endmodule

`default_nettype wire

// ----- design/knn_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No dependencies.
`default_nettype none

module knn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- tb/knn_checker.sv -----
// Result checker for the k-nearest-neighbor classifier.
// Mirrors the configuration and stores, predicts each result word, compares.
// Depends on knn_pkg.
`default_nettype none

module knn_checker
    import knn_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgW-1:0]     i_cfg_data,
    input  wire logic                s_axis_tvalid,
    input  wire logic                s_axis_tready,
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    input  wire logic [FuncW-1:0]    s_axis_tuser,
    input  wire logic                s_axis_tlast,
    input  wire logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    input  wire logic [OutDataW-1:0] m_axis_tdata,
    input  wire logic                m_axis_tlast,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [LabW-1:0]  cls;
        logic [VoteW-1:0] votes;
        logic [LabW-1:0]  decided;
        logic [RadW-1:0]  radius;
        logic             short_flag;
        logic             last_flag;
    } t_vote_result;

    // mirrored configuration, raw register values
    logic [8:0] k_reg;
    logic [8:0] samples_reg;
    logic [4:0] dims_reg;
    logic [3:0] classes_reg;

    logic [15:0] coord_mem [256][16];
    logic [3:0]  label_mem [256];
    logic [15:0] query_mem [16];

    t_vote_result expected_votes_q[$];

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned root;
        longint unsigned b_sel;
        root = 0;
        b_sel = 64'd1 << 62;
        while (b_sel > v) b_sel >>= 2;
        while (b_sel != 0) begin
            if (v >= root + b_sel) begin
                v -= root + b_sel;
                root = (root >> 1) + b_sel;
            end else begin
                root >>= 1;
            end
            b_sel >>= 2;
        end
        return root;
    endfunction

    // Work out the nc result words of one classification.
    task automatic classify_query();
        int ns, nd, nc, k, pick, best_cls, best_votes;
        longint unsigned sample_dist [256];
        bit taken [256];
        int votes [8];
        longint unsigned acc, kth, best;
        longint sd;
        bit found, short_flag;
        t_vote_result v;
        ns = (samples_reg > 256) ? 256 : samples_reg;
        nd = (dims_reg > 16) ? 16 : dims_reg;
        nc = (classes_reg > 8) ? 8 : classes_reg;
        if (nc == 0) nc = 1;
        k = k_reg;
        for (int s = 0; s < ns; s++) begin
            acc = 0;
            for (int d = 0; d < nd; d++) begin
                sd = longint'($signed(coord_mem[s][d])) - longint'($signed(query_mem[d]));
                acc += longint'(sd * sd);
            end
            sample_dist[s] = acc;
            taken[s] = 0;
        end
        for (int c = 0; c < 8; c++) votes[c] = 0;
        kth = 0;
        short_flag = 0;
        // pick the nearest nonzero distance k times, lowest index on ties
        for (int r = 0; r < k; r++) begin
            found = 0;
            pick = 0;
            best = 0;
            for (int s = 0; s < ns; s++) begin
                if (!taken[s] && sample_dist[s] != 0 && (!found || sample_dist[s] < best)) begin
                    found = 1;
                    best = sample_dist[s];
                    pick = s;
                end
            end
            if (!found) begin
                short_flag = 1;
                break;
            end
            taken[pick] = 1;
            kth = best;
            if (label_mem[pick] >= 1 && label_mem[pick] <= nc)
                votes[label_mem[pick] - 1]++;
        end
        best_cls = 0;
        best_votes = 0;
        for (int c = 0; c < nc; c++) begin
            if (votes[c] > best_votes) begin
                best_votes = votes[c];
                best_cls = c;
            end
        end
        for (int c = 0; c < nc; c++) begin
            v.cls = LabW'(c + 1);
            v.votes = VoteW'(votes[c]);
            v.decided = LabW'(best_cls + 1);
            v.radius = RadW'(int_root(kth));
            v.short_flag = short_flag;
            v.last_flag = (c + 1 == nc);
            expected_votes_q.push_back(v);
        end
    endtask

    always @(posedge i_clk) begin
        t_vote_result got, want;
        logic [7:0] si;
        logic [3:0] di;
        if (!i_rst_n) begin
            k_reg <= 9'd1;
            samples_reg <= 9'd256;
            dims_reg <= 5'd16;
            classes_reg <= 4'd8;
            o_fail_count = 0;
        end else begin
            // compare a result word with the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got.cls = m_axis_tdata[3:0];
                got.votes = m_axis_tdata[12:4];
                got.decided = m_axis_tdata[16:13];
                got.radius = m_axis_tdata[35:17];
                got.short_flag = m_axis_tdata[36];
                got.last_flag = m_axis_tlast;
                if (expected_votes_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word: %p", got);
                end else begin
                    want = expected_votes_q.pop_front();
                    if (got != want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("result mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NEIGHBOURS: k_reg <= i_cfg_data;
                    CFG_SAMPLES:    samples_reg <= i_cfg_data;
                    CFG_DIMS:       dims_reg <= i_cfg_data[4:0];
                    CFG_CLASSES:    classes_reg <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // update the stores with an accepted input word
            if (s_axis_tvalid && s_axis_tready) begin
                si = s_axis_tdata[7:0];
                di = s_axis_tdata[11:8];
                case (s_axis_tuser)
                    FUNC_SAMPLE: coord_mem[si][di] = s_axis_tdata[27:12];
                    FUNC_LABEL:  label_mem[si] = s_axis_tdata[31:28];
                    FUNC_QUERY: begin
                        query_mem[di] = s_axis_tdata[27:12];
                        if (s_axis_tlast) classify_query();
                    end
                    default: ;
                endcase
            end
        end
        o_pending = expected_votes_q.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb_knn_classifier_unit.sv -----
// Testbench top for knn_classifier_unit: clock, reset, stimulus and verdict.
// Depends on knn_pkg, knn_classifier_unit and knn_checker.
`default_nettype none

module tb_knn_classifier_unit;
    import knn_pkg::*;

    localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;
    localparam int IdleLimit = 300000;
    localparam int LongHold = 3000;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_cfg_we = 0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgW-1:0]     i_cfg_data = '0;
    logic                s_axis_tvalid = 0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic [FuncW-1:0]    s_axis_tuser = '0;
    logic                s_axis_tlast = 0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tlast;
    int                  fail_count;
    int                  pending;

    // effective sizes used to keep every store read defined
    int ns_eff, nd_eff, nc_eff;
    bit coord_written [256][16];
    bit label_written [256];
    bit query_written [16];
    int burst_left = 0;
    int word_count = 0;
    bit long_hold_req = 0;

    always #2 i_clk = ~i_clk;

    knn_classifier_unit dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
    );

    knn_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stretches of full rate and of random stalls, plus one long hold.
    always @(posedge i_clk) begin
        int rx_left, rx_mode, hold_cnt;
        if (long_hold_req) begin
            m_axis_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= LongHold) begin
                long_hold_req = 0;
                hold_cnt = 0;
            end
        end else begin
            if (rx_left <= 0) begin
                rx_left = $urandom_range(5, 60);
                rx_mode = $urandom_range(0, 2);
            end
            rx_left--;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: end the run after a long stretch without any accepted word.
    always @(posedge i_clk) begin
        int idle_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 4))
            0, 1: return 16'($signed($urandom_range(0, 6)) - 3);
            2:    return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one word and hold it until accepted; close bursts with random gaps.
    task automatic put_word(logic [1:0] fn, logic [7:0] si, logic [3:0] di,
                            logic [15:0] val, logic [3:0] lab, logic lst);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {lab, val, di, si};
        s_axis_tuser <= fn;
        s_axis_tlast <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        word_count++;
        case (fn)
            FUNC_SAMPLE: coord_written[si][di] = 1;
            FUNC_LABEL:  label_written[si] = 1;
            FUNC_QUERY:  query_written[di] = 1;
            default: ;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    // Pause until every expected result is in and the block is idle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic configure(int k, int ns, int nd, int nc);
        int vals [4];
        vals = '{k, ns, nd, nc};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= CfgIdxW'(r);
            i_cfg_data <= CfgW'(vals[r]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        ns_eff = (ns > 256) ? 256 : ns;
        nd_eff = (nd > 16) ? 16 : nd;
        nc_eff = (nc > 8) ? 8 : ((nc == 0) ? 1 : nc);
    endtask

    // Write any store entry that the next classification would read unwritten.
    // With no coordinates in use no store is read at all.
    task automatic fill_missing();
        if (nd_eff == 0) return;
        for (int s = 0; s < ns_eff; s++) begin
            for (int d = 0; d < nd_eff; d++)
                if (!coord_written[s][d])
                    put_word(FUNC_SAMPLE, 8'(s), 4'(d), pick_coord(), 4'($urandom), 0);
            if (!label_written[s])
                put_word(FUNC_LABEL, 8'(s), 4'($urandom), 16'($urandom),
                         4'($urandom_range(1, nc_eff)), 0);
        end
        for (int d = 0; d < nd_eff; d++)
            if (!query_written[d])
                put_word(FUNC_QUERY, 8'($urandom), 4'(d), pick_coord(), 4'($urandom), 0);
    endtask

    // One well-formed query with random training updates and some noise words.
    task automatic run_query();
        int updates;
        int di_order [$];
        logic [3:0] lab;
        updates = $urandom_range(0, 6);
        for (int u = 0; u < updates; u++) begin
            case ($urandom_range(0, 5))
                0, 1, 2: put_word(FUNC_SAMPLE, 8'($urandom_range(0, ns_eff - 1)),
                                  4'($urandom), pick_coord(), 4'($urandom), 1'($urandom));
                3: begin
                    lab = ($urandom_range(0, 4) == 0) ? 4'($urandom)
                                                      : 4'($urandom_range(1, nc_eff));
                    put_word(FUNC_LABEL, 8'($urandom_range(0, ns_eff - 1)),
                             4'($urandom), 16'($urandom), lab, 1'($urandom));
                end
                4: put_word(FUNC_UNUSED, 8'($urandom), 4'($urandom), 16'($urandom),
                            4'($urandom), 1'($urandom));
                default: put_word(FUNC_SAMPLE, 8'($urandom), 4'($urandom), pick_coord(),
                                  4'($urandom), 0);
            endcase
        end
        fill_missing();
        for (int d = 0; d < nd_eff; d++) di_order.push_back(d);
        di_order.shuffle();
        if (di_order.size() == 0) di_order.push_back($urandom_range(0, 15));
        foreach (di_order[j])
            put_word(FUNC_QUERY, 8'($urandom), 4'(di_order[j]), pick_coord(),
                     4'($urandom), j == di_order.size() - 1);
    endtask

    task automatic random_phase(int words);
        int stop_at;
        stop_at = word_count + words;
        while (word_count < stop_at) run_query();
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, zero distance, equal distances, odd labels, noise.
        configure(3, 6, 3, 4);
        for (int d = 0; d < 3; d++) begin
            put_word(FUNC_SAMPLE, 8'd0, 4'(d), 16'h7fff, 4'd0, 0);
            put_word(FUNC_SAMPLE, 8'd1, 4'(d), 16'h8000, 4'd0, 1);
            put_word(FUNC_SAMPLE, 8'd2, 4'(d), 16'h0000, 4'd0, 0);
            put_word(FUNC_SAMPLE, 8'd3, 4'(d), (d == 0) ? 16'd1 : 16'd0, 4'd0, 0);
            put_word(FUNC_SAMPLE, 8'd4, 4'(d), (d == 1) ? 16'd1 : 16'd0, 4'd0, 0);
            put_word(FUNC_SAMPLE, 8'd5, 4'(d), (d == 2) ? 16'hffff : 16'd0, 4'd0, 0);
        end
        put_word(FUNC_LABEL, 8'd0, 4'd0, 16'd0, 4'd1, 0);
        put_word(FUNC_LABEL, 8'd1, 4'd0, 16'd0, 4'd4, 0);
        put_word(FUNC_LABEL, 8'd2, 4'd0, 16'd0, 4'd2, 0);
        put_word(FUNC_LABEL, 8'd3, 4'd0, 16'd0, 4'd4, 0);
        put_word(FUNC_LABEL, 8'd4, 4'd0, 16'd0, 4'd0, 0);
        put_word(FUNC_LABEL, 8'd5, 4'd0, 16'd0, 4'd15, 0);
        put_word(FUNC_UNUSED, 8'hff, 4'hf, 16'hffff, 4'hf, 1);
        for (int d = 0; d < 3; d++)
            put_word(FUNC_QUERY, 8'd0, 4'(d), 16'd0, 4'd0, d == 2);
        for (int d = 0; d < 3; d++)
            put_word(FUNC_QUERY, 8'hff, 4'(d), 16'h7fff, 4'hf, d == 2);
        drain();

        // Random with a long receiver hold while the sender keeps offering.
        long_hold_req = 1;
        random_phase(40);
        configure(1, 1, 1, 1);
        random_phase(20);
        configure(0, 4, 16, 8);
        random_phase(25);
        configure(511, 5, 31, 15);
        random_phase(20);
        configure(2, 511, 0, 0);
        random_phase(10);
        configure(256, 24, 1, 8);
        random_phase(20);
        configure(4, 12, 5, 3);
        random_phase(40);

        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
design/knn_pkg.sv
design/knn_ram.sv
design/knn_classifier_unit.sv
tb/knn_checker.sv
tb/tb_knn_classifier_unit.sv
